>>> rtl/core/brcs_pkg.sv
// ----------------------------------------------------------------------------
// brcs_pkg: shared types and helpers for the blit rectangle clip setup
// Payload structs, configuration register indexes, status codes and the
// per-axis clip function.
// ----------------------------------------------------------------------------
`default_nettype none

package brcs_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEST_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DEST_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DEST_PITCH  = 2'd2;
  localparam logic [1:0] CFG_BPP         = 2'd3;

  // Saturation limits.
  localparam logic [17:0] ROW_BYTES_MAX = 18'h3FFFF;
  localparam logic [31:0] OFFSET_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SRC_EMPTY = 2'd1,
    ST_DST_EMPTY = 2'd2,
    ST_FORMAT    = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] src_width;
    logic [15:0] src_height;
    logic [15:0] src_pitch;
    logic        src_has_rect;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic [15:0] src_w;
    logic [15:0] src_h;
    logic        dst_has_rect;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic        formats_match;
  } brcs_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] clip_src_x;
    logic [15:0] clip_src_y;
    logic [15:0] clip_dst_x;
    logic [15:0] clip_dst_y;
    logic [15:0] copy_width;
    logic [15:0] row_count;
    logic [17:0] row_bytes;
    logic [31:0] src_offset;
    logic [31:0] dst_offset;
  } brcs_out_t;

  typedef struct packed {
    logic [15:0] dest_width;
    logic [15:0] dest_height;
    logic [15:0] dest_pitch;
    logic [2:0]  bpp;
  } brcs_cfg_t;

  // Clipped geometry handed from the clip stage to the offset stage.
  typedef struct packed {
    status_t     status;
    logic [15:0] src_pitch;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] w;
    logic [15:0] h;
  } brcs_clip_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] size;
  } brcs_axis_t;

  // Clip one axis: a negative origin moves to zero and eats into the size,
  // then the far edge is trimmed to the surface extent.
  function automatic brcs_axis_t clip_axis(input logic signed [15:0] p,
                                           input logic [15:0] n,
                                           input logic [15:0] e);
    logic signed [18:0] pp;
    logic signed [18:0] nn;
    logic signed [18:0] lim;
    brcs_axis_t         res;
    pp  = {{3{p[15]}}, p};
    nn  = {3'b000, n};
    lim = {3'b000, e};
    if (pp < 19'sd0) begin
      nn = nn + pp;
      if (nn < 19'sd0) begin
        nn = 19'sd0;
      end
      pp = 19'sd0;
    end
    if ((pp + nn) > lim) begin
      nn = lim - pp;
      if (nn < 19'sd0) begin
        nn = 19'sd0;
      end
    end
    res.pos  = pp[15:0];
    res.size = nn[15:0];
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/brcs_clip.sv
// ----------------------------------------------------------------------------
// brcs_clip: rectangle clipping
// Clips the source rectangle to the source surface and the destination
// rectangle to the destination surface, and picks the status code.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_clip
  import brcs_pkg::*;
(
  input  var brcs_in_t   req,
  input  var brcs_cfg_t  cfg,
  output brcs_clip_t     clip
);

  brcs_axis_t src_cx;
  brcs_axis_t src_cy;
  brcs_axis_t dst_cx;
  brcs_axis_t dst_cy;
  logic [15:0] sx;
  logic [15:0] sy;
  logic [15:0] sw;
  logic [15:0] sh;
  logic signed [15:0] dx_in;
  logic signed [15:0] dy_in;
  logic src_empty;
  logic dst_empty;

  // Source side: the given rectangle, or the whole surface.
  assign src_cx = clip_axis(req.src_x, req.src_w, req.src_width);
  assign src_cy = clip_axis(req.src_y, req.src_h, req.src_height);

  always_comb begin
    if (req.src_has_rect) begin
      sx = src_cx.pos;
      sy = src_cy.pos;
      sw = src_cx.size;
      sh = src_cy.size;
    end else begin
      sx = 16'd0;
      sy = 16'd0;
      sw = req.src_width;
      sh = req.src_height;
    end
  end

  assign src_empty = req.src_has_rect && ((sw == 16'd0) || (sh == 16'd0));

  // Destination side takes the source size.
  assign dx_in = req.dst_has_rect ? req.dst_x : 16'sd0;
  assign dy_in = req.dst_has_rect ? req.dst_y : 16'sd0;
  assign dst_cx = clip_axis(dx_in, sw, cfg.dest_width);
  assign dst_cy = clip_axis(dy_in, sh, cfg.dest_height);
  assign dst_empty = (dst_cx.size == 16'd0) || (dst_cy.size == 16'd0);

  // Status and clipped geometry.
  always_comb begin
    if (src_empty) begin
      clip.status = ST_SRC_EMPTY;
    end else if (dst_empty) begin
      clip.status = ST_DST_EMPTY;
    end else if (req.formats_match) begin
      clip.status = ST_OK;
    end else begin
      clip.status = ST_FORMAT;
    end
    clip.src_pitch = req.src_pitch;
    clip.sx        = sx;
    clip.sy        = sy;
    clip.dx        = dst_cx.pos;
    clip.dy        = dst_cy.pos;
    clip.w         = dst_cx.size;
    clip.h         = dst_cy.size;
  end

endmodule

`default_nettype wire

>>> rtl/core/brcs_offset.sv
// ----------------------------------------------------------------------------
// brcs_offset: byte offset and row length
// Forms the start byte offsets and the row length from the clipped geometry,
// with saturation, and zeroes the fields of empty results.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_offset
  import brcs_pkg::*;
(
  input  var brcs_clip_t clip,
  input  var brcs_cfg_t  cfg,
  output brcs_out_t      res
);

  logic [31:0] src_row_prod;
  logic [31:0] dst_row_prod;
  logic [18:0] src_col_prod;
  logic [18:0] dst_col_prod;
  logic [32:0] src_sum;
  logic [32:0] dst_sum;
  logic [18:0] rb_prod;
  logic        empty;

  // Pitch times row plus column times bytes per pixel.
  assign src_row_prod = 32'(clip.src_pitch) * 32'(clip.sy);
  assign dst_row_prod = 32'(cfg.dest_pitch) * 32'(clip.dy);
  assign src_col_prod = 19'(clip.sx) * 19'(cfg.bpp);
  assign dst_col_prod = 19'(clip.dx) * 19'(cfg.bpp);
  assign src_sum = {1'b0, src_row_prod} + {14'd0, src_col_prod};
  assign dst_sum = {1'b0, dst_row_prod} + {14'd0, dst_col_prod};
  assign rb_prod = 19'(clip.w) * 19'(cfg.bpp);

  assign empty = (clip.status == ST_SRC_EMPTY) || (clip.status == ST_DST_EMPTY);

  // Empty results carry only their status.
  always_comb begin
    res.status = clip.status;
    if (empty) begin
      res.clip_src_x = 16'd0;
      res.clip_src_y = 16'd0;
      res.clip_dst_x = 16'd0;
      res.clip_dst_y = 16'd0;
      res.copy_width = 16'd0;
      res.row_count  = 16'd0;
      res.row_bytes  = 18'd0;
      res.src_offset = 32'd0;
      res.dst_offset = 32'd0;
    end else begin
      res.clip_src_x = clip.sx;
      res.clip_src_y = clip.sy;
      res.clip_dst_x = clip.dx;
      res.clip_dst_y = clip.dy;
      res.copy_width = clip.w;
      res.row_count  = clip.h;
      res.row_bytes  = rb_prod[18] ? ROW_BYTES_MAX : rb_prod[17:0];
      res.src_offset = src_sum[32] ? OFFSET_MAX : src_sum[31:0];
      res.dst_offset = dst_sum[32] ? OFFSET_MAX : dst_sum[31:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/blit_rect_clip_setup.sv
// ----------------------------------------------------------------------------
// blit_rect_clip_setup: blit rectangle clip and offset setup
// A request beat that is taken passes the input register, clip register and
// result register in turn. Throughput: one request per cycle while out_stall
// is low, set by the three-stage register pipeline.
// Reset: synchronous active-low rst_n empties the pipeline and sets the
// destination size and pitch to zero and bytes per pixel to one.
// ----------------------------------------------------------------------------
`default_nettype none

module blit_rect_clip_setup
  import brcs_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  var brcs_in_t in_data,
  output logic       out_valid,
  input  wire        out_stall,
  output brcs_out_t  out_data,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_addr,
  input  wire [15:0] cfg_wdata
);

  brcs_cfg_t  cfg_r;
  brcs_in_t   req_r;
  brcs_clip_t clip_r;
  brcs_clip_t clip_nxt;
  brcs_out_t  res_r;
  brcs_out_t  res_nxt;
  logic       v0_r;
  logic       v1_r;
  logic       v2_r;
  logic       adv0;
  logic       adv1;
  logic       adv2;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width  <= 16'd0;
      cfg_r.dest_height <= 16'd0;
      cfg_r.dest_pitch  <= 16'd0;
      cfg_r.bpp         <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEST_WIDTH:  cfg_r.dest_width  <= cfg_wdata;
        CFG_DEST_HEIGHT: cfg_r.dest_height <= cfg_wdata;
        CFG_DEST_PITCH:  cfg_r.dest_pitch  <= cfg_wdata;
        CFG_BPP:         cfg_r.bpp         <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Each stage moves when the one after it is empty or moving.
  assign adv2     = !v2_r || !out_stall;
  assign adv1     = !v1_r || adv2;
  assign adv0     = !v0_r || adv1;
  assign in_stall = !adv0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv0) begin
        v0_r <= in_valid;
      end
      if (adv1) begin
        v1_r <= v0_r;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (adv0) begin
      req_r <= in_data;
    end
    if (adv1) begin
      clip_r <= clip_nxt;
    end
    if (adv2) begin
      res_r <= res_nxt;
    end
  end

  brcs_clip u_clip (
    .req  (req_r),
    .cfg  (cfg_r),
    .clip (clip_nxt)
  );

  brcs_offset u_offset (
    .clip (clip_r),
    .cfg  (cfg_r),
    .res  (res_nxt)
  );

  assign out_valid = v2_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire

>>> verif/blit_rect_clip_setup_test.sv
// ----------------------------------------------------------------------------
// blit_rect_clip_setup_test: self-checking bench for the blit clip setup
// Drives blit requests through the valid/stall input channel and checks each
// result beat against a behavioral predictor of the clip and offset math. The
// destination surface registers are rewritten between phases while the block
// is idle, and both channels idle and stall at random.
// ----------------------------------------------------------------------------

module blit_rect_clip_setup_test;
  import brcs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  // Predictor and store of expected setups, with its own copy of the
  // destination surface registers.
  class setup_checker;
    logic [15:0] dest_w = '0;
    logic [15:0] dest_h = '0;
    logic [15:0] dest_pitch = '0;
    logic [2:0]  bpp = 3'd1;
    brcs_out_t   pending_setups[$];
    int          errors = 0;

    // Clip one axis in place and return the remaining size.
    function int trim_axis(inout int org, input int size, input int extent);
      if (org < 0) begin
        size = size + org;
        if (size < 0) size = 0;
        org = 0;
      end
      if (org + size > extent) begin
        size = extent - org;
        if (size < 0) size = 0;
      end
      return size;
    endfunction

    function longint unsigned cap(longint unsigned v, longint unsigned top);
      return (v > top) ? top : v;
    endfunction

    function brcs_out_t predict_setup(brcs_in_t r);
      brcs_out_t o;
      int sx, sy, dx, dy, w, h;
      o = '0;
      sx = 0;
      sy = 0;
      dx = 0;
      dy = 0;
      // Source rectangle, or the whole source surface.
      if (r.src_has_rect) begin
        sx = int'(r.src_x);
        sy = int'(r.src_y);
        w = trim_axis(sx, int'(r.src_w), int'(r.src_width));
        h = trim_axis(sy, int'(r.src_h), int'(r.src_height));
        if (w <= 0 || h <= 0) begin
          o.status = ST_SRC_EMPTY;
          return o;
        end
      end else begin
        w = int'(r.src_width);
        h = int'(r.src_height);
      end
      // Destination takes the source size; the source origin stays put.
      if (r.dst_has_rect) begin
        dx = int'(r.dst_x);
        dy = int'(r.dst_y);
      end
      w = trim_axis(dx, w, int'(dest_w));
      h = trim_axis(dy, h, int'(dest_h));
      if (w <= 0 || h <= 0) begin
        o.status = ST_DST_EMPTY;
        return o;
      end
      o.status     = r.formats_match ? ST_OK : ST_FORMAT;
      o.clip_src_x = sx[15:0];
      o.clip_src_y = sy[15:0];
      o.clip_dst_x = dx[15:0];
      o.clip_dst_y = dy[15:0];
      o.copy_width = w[15:0];
      o.row_count  = h[15:0];
      o.row_bytes  = 18'(cap(longint'(w) * longint'(bpp), 64'h3FFFF));
      o.src_offset = 32'(cap(longint'(r.src_pitch) * longint'(sy) + longint'(sx) * longint'(bpp),
                             64'hFFFF_FFFF));
      o.dst_offset = 32'(cap(longint'(dest_pitch) * longint'(dy) + longint'(dx) * longint'(bpp),
                             64'hFFFF_FFFF));
      return o;
    endfunction

    function void note_request(brcs_in_t r);
      pending_setups.push_back(predict_setup(r));
    endfunction

    function void field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_setup(brcs_out_t got);
      brcs_out_t want;
      if (pending_setups.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      want = pending_setups.pop_front();
      field("status", 32'(want.status), 32'(got.status));
      field("clip_src_x", 32'(want.clip_src_x), 32'(got.clip_src_x));
      field("clip_src_y", 32'(want.clip_src_y), 32'(got.clip_src_y));
      field("clip_dst_x", 32'(want.clip_dst_x), 32'(got.clip_dst_x));
      field("clip_dst_y", 32'(want.clip_dst_y), 32'(got.clip_dst_y));
      field("copy_width", 32'(want.copy_width), 32'(got.copy_width));
      field("row_count", 32'(want.row_count), 32'(got.row_count));
      field("row_bytes", 32'(want.row_bytes), 32'(got.row_bytes));
      field("src_offset", want.src_offset, got.src_offset);
      field("dst_offset", want.dst_offset, got.dst_offset);
    endfunction

    function int pending();
      return pending_setups.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  brcs_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  brcs_out_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  setup_checker board;
  bit  gaps_on = 1'b0;
  bit  stalls_on = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;

  blit_rect_clip_setup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("blit_rect_clip_setup_test: FAIL");
      $finish;
    end
  end

  // Check result beats and record request beats at the edge that takes them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_setup(out_data);
      if (in_valid && !in_stall) board.note_request(in_data);
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Receiver back-pressure, with a long hold-off on request.
  initial begin
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0 && free_left == 0) begin
          free_left = $urandom_range(1, 12);
          stall_left = stalls_on ? pick_gap() : 0;
        end
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          free_left--;
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Size that mostly lands around the given extent.
  function automatic int span_near(int lim);
    if ($urandom_range(0, 9) < 8) return clamp(int'($urandom_range(0, lim + lim / 4 + 2)), 0, 65535);
    return $urandom_range(0, 65535);
  endfunction

  // Origin that mostly lands around the given extent, negatives included.
  function automatic int pos_near(int lim);
    if ($urandom_range(0, 9) < 8)
      return clamp(int'($urandom_range(0, lim + lim / 4 + 8)) - lim / 8 - 4, -32768, 32767);
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic brcs_in_t make_request(int sw, int sh, int pitch, bit hs, int sx, int sy,
                                            int w, int h, bit hd, int dx, int dy, bit m);
    brcs_in_t r;
    r.src_width     = sw[15:0];
    r.src_height    = sh[15:0];
    r.src_pitch     = pitch[15:0];
    r.src_has_rect  = hs;
    r.src_x         = sx[15:0];
    r.src_y         = sy[15:0];
    r.src_w         = w[15:0];
    r.src_h         = h[15:0];
    r.dst_has_rect  = hd;
    r.dst_x         = dx[15:0];
    r.dst_y         = dy[15:0];
    r.formats_match = m;
    return r;
  endfunction

  // Mostly requests shaped around the current surfaces, some pure noise.
  function automatic brcs_in_t random_request();
    int sw, sh;
    if ($urandom_range(0, 9) == 0)
      return make_request($urandom, $urandom, $urandom, 1'($urandom), $urandom, $urandom,
                          $urandom, $urandom, 1'($urandom), $urandom, $urandom,
                          1'($urandom));
    sw = span_near(int'(board.dest_w));
    sh = span_near(int'(board.dest_h));
    return make_request(sw, sh, $urandom, $urandom_range(0, 3) != 0,
                        pos_near(sw), pos_near(sh), span_near(sw), span_near(sh),
                        $urandom_range(0, 3) != 0,
                        pos_near(int'(board.dest_w)), pos_near(int'(board.dest_h)),
                        $urandom_range(0, 7) != 0);
  endfunction

  // Offer one request beat and hold it until the block takes it.
  task automatic send_request(input brcs_in_t r);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEST_WIDTH:  board.dest_w = val;
      CFG_DEST_HEIGHT: board.dest_h = val;
      CFG_DEST_PITCH:  board.dest_pitch = val;
      CFG_BPP:         board.bpp = val[2:0];
      default: ;
    endcase
  endtask

  // Stop offering the beat already taken, then let the pipeline drain.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Bytes per pixel gets junk in the unused upper bits.
  task automatic apply_setting(input int w, input int h, input int p, input int b);
    wait_idle();
    write_reg(CFG_DEST_WIDTH, w[15:0]);
    write_reg(CFG_DEST_HEIGHT, h[15:0]);
    write_reg(CFG_DEST_PITCH, p[15:0]);
    write_reg(CFG_BPP, {13'($urandom), b[2:0]});
  endtask

  initial begin
    board = new;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_DEST_WIDTH;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset surfaces are empty, so every request comes back empty.
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (40) send_request(random_request());

    // Directed requests against a 100 x 80 destination.
    apply_setting(100, 80, 400, 4);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_request(make_request(64, 48, 256, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_request(make_request(64, 48, 256, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(64, 48, 256, 1, 10, 5, 20, 10, 1, 30, 20, 1));
    send_request(make_request(64, 48, 256, 1, 10, 5, 0, 10, 1, 0, 0, 1));
    send_request(make_request(64, 48, 256, 1, 64, 0, 5, 5, 0, 0, 0, 1));
    send_request(make_request(64, 48, 256, 1, -10, 0, 5, 5, 0, 0, 0, 1));
    send_request(make_request(64, 48, 256, 1, -3, -2, 10, 10, 1, 5, 5, 1));
    send_request(make_request(0, 0, 256, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_request(make_request(64, 48, 256, 0, 0, 0, 0, 0, 1, 100, 0, 1));
    send_request(make_request(64, 48, 256, 0, 0, 0, 0, 0, 1, -5, -7, 1));
    send_request(make_request(64, 48, 256, 0, 0, 0, 0, 0, 1, -32768, 0, 1));
    send_request(make_request(64, 48, 256, 1, 50, 40, 30, 30, 1, 90, 70, 1));
    send_request(make_request(65535, 65535, 65535, 1, 32767, 32767, 65535, 65535,
                              1, 32767, 32767, 1));
    send_request(make_request(65535, 65535, 65535, 1, -32768, -32768, 65535, 65535,
                              1, 0, 0, 1));
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(65535, 65535, 65535, 1, -1, -1, 65535, 65535, 1, -1, -1, 1));
    send_request(make_request(64, 48, 256, 1, 63, 47, 1, 1, 1, 99, 79, 1));
    send_request(make_request(30, 20, 256, 0, -5, 7, 0, 0, 0, 55, 55, 1));

    // Random phases across several destination settings.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: apply_setting(100, 80, 400, 4);
        1: apply_setting(65535, 65535, 65535, 4);
        2: apply_setting(65535, 65535, 65535, 7);
        3: apply_setting(1, 1, 1, 1);
        4: apply_setting(0, 65535, 123, 2);
        5: apply_setting(640, 480, 2560, 3);
        6: apply_setting(32, 16, 128, 0);
        7: apply_setting(4000, 3000, 16000, 5);
        8: apply_setting($urandom_range(1, 2048), $urandom_range(1, 2048),
                         $urandom_range(0, 65535), $urandom_range(0, 7));
        default: apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 7));
      endcase
      gaps_on = (ph % 3 == 0);
      stalls_on = (ph % 3 != 1);
      // Receiver holds off long enough for the pipeline to back up.
      if (ph == 5) begin
        gaps_on = 1'b0;
        hold_left = 400;
      end
      repeat (141) send_request(random_request());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("blit_rect_clip_setup_test: PASS");
    end else begin
      $display("blit_rect_clip_setup_test: FAIL");
    end
    $finish;
  end

endmodule
